// File: src/ipt_pkg.sv
// ----------------------------------------------------------------------------
// ipt_pkg
// Shared types and constants of the indexed priority table: operation codes,
// controller states and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
package ipt_pkg;

	localparam int DEF_TABLE_ENTRIES = 64;
	localparam int DEF_PRIORITY_BITS = 10;
	localparam int ID_W              = 6;
	localparam int AMOUNT_W          = 10;
	localparam int STAMP_W           = 32;
	localparam int OP_W              = 2;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT   = 2'd0,
		OP_INCREASE = 2'd1,
		OP_REMOVE   = 2'd2,
		OP_QUERY    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_MODIFY,
		ST_SCAN,
		ST_DRAIN,
		ST_REPORT
	} state_t;

	typedef struct packed {
		logic latch;
		logic clr_we;
		logic cnt_clr;
		logic cnt_inc;
		logic wr_item;
		logic rd_item;
		logic wr_incr;
		logic scan_rd;
		logic best_clr;
		logic out_load;
	} ipt_cmd_t;

	typedef struct packed {
		op_t  op;
		logic in_range;
		logic cnt_last;
		logic rd_valid;
		logic out_free;
	} ipt_sts_t;

endpackage

// File: src/ipt_dp.sv
// ----------------------------------------------------------------------------
// ipt_dp
// Datapath: item register, entry memory {valid, priority, stamp}, stamp
// counter, sweep counter, best-entry compare and the result register.
// ----------------------------------------------------------------------------
module ipt_dp import ipt_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ipt_cmd_t    cmd,
	output ipt_sts_t    sts,
	input  logic [15:0] s_tdata,
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,
	output logic [0:0]  m_tuser
);

	localparam int AW    = $clog2(TABLE_ENTRIES);
	localparam int PB    = PRIORITY_BITS;
	localparam int SW    = ((PB > AMOUNT_W) ? PB : AMOUNT_W) + 1;
	localparam int IDX_W = ((AW > ID_W) ? AW : ID_W) + 1;
	localparam int WW    = 1 + PB + STAMP_W;

	logic [ID_W-1:0]     in_id;
	logic [AMOUNT_W-1:0] in_amount;
	logic [AW+ID_W-1:0]  in_id_wide;

	op_t                 item_op_q;
	logic [AW-1:0]       item_addr_q;
	logic                item_in_range_q;
	logic [AMOUNT_W-1:0] item_amount_q;

	logic [STAMP_W-1:0]  stamp_q;
	logic [AW-1:0]       cnt_q;

	logic [WW-1:0]       mem [TABLE_ENTRIES];
	logic [WW-1:0]       rdata_q;
	logic                mem_we;
	logic [AW-1:0]       waddr;
	logic [WW-1:0]       wdata;
	logic                mem_re;
	logic [AW-1:0]       raddr;

	logic                rd_v;
	logic [PB-1:0]       rd_prio;
	logic [STAMP_W-1:0]  rd_stamp;

	logic [SW-1:0]       prio_max_ext;
	logic [SW-1:0]       amt_ext;
	logic [SW-1:0]       sum_ext;
	logic [PB-1:0]       ins_prio;
	logic [PB-1:0]       inc_prio;

	logic                cmp_vld_s1;
	logic [AW-1:0]       cmp_id_s1;
	logic                cmp_win;
	logic                best_found_q;
	logic [PB-1:0]       best_prio_q;
	logic [STAMP_W-1:0]  best_stamp_q;
	logic [AW-1:0]       best_id_q;
	logic [AW+ID_W-1:0]  best_id_wide;

	logic                out_valid_q;
	logic [ID_W-1:0]     out_id_q;
	logic                out_empty_q;

	assign in_id      = s_tdata[ID_W-1:0];
	assign in_amount  = s_tdata[ID_W+AMOUNT_W-1:ID_W];
	assign in_id_wide = {{AW{1'b0}}, in_id};

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_op_q       <= op_t'(s_tuser);
			item_addr_q     <= in_id_wide[AW-1:0];
			item_in_range_q <= ({{(IDX_W-ID_W){1'b0}}, in_id} < IDX_W'(TABLE_ENTRIES));
			item_amount_q   <= in_amount;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_q <= '0;
		end else if (cmd.wr_item && item_op_q == OP_INSERT) begin
			stamp_q <= stamp_q + STAMP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + AW'(1);
		end
	end

	// priority saturation
	assign rd_v         = rdata_q[WW-1];
	assign rd_prio      = rdata_q[WW-2 -: PB];
	assign rd_stamp     = rdata_q[STAMP_W-1:0];
	assign prio_max_ext = {{(SW-PB){1'b0}}, {PB{1'b1}}};
	assign amt_ext      = {{(SW-AMOUNT_W){1'b0}}, item_amount_q};
	assign sum_ext      = {{(SW-PB){1'b0}}, rd_prio} + amt_ext;
	assign ins_prio     = (amt_ext > prio_max_ext) ? {PB{1'b1}} : amt_ext[PB-1:0];
	assign inc_prio     = (sum_ext > prio_max_ext) ? {PB{1'b1}} : sum_ext[PB-1:0];

	always_comb begin
		mem_we = cmd.clr_we | cmd.wr_item | cmd.wr_incr;
		waddr  = cmd.clr_we ? cnt_q : item_addr_q;
		wdata  = '0;
		if (cmd.wr_incr) begin
			wdata = {1'b1, inc_prio, rd_stamp};
		end else if (cmd.wr_item && item_op_q == OP_INSERT) begin
			wdata = {1'b1, ins_prio, stamp_q};
		end
		mem_re = cmd.rd_item | cmd.scan_rd;
		raddr  = cmd.rd_item ? item_addr_q : cnt_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rdata_q <= mem[raddr];
		end
	end

	// scan compare, one entry per cycle; strict wins keep the lower id on full ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.scan_rd;
		end
	end

	always_ff @(posedge clk) begin
		cmp_id_s1 <= cnt_q;
	end

	assign cmp_win = rd_v && (!best_found_q || rd_prio > best_prio_q ||
		(rd_prio == best_prio_q && rd_stamp < best_stamp_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_found_q <= 1'b0;
		end else if (cmd.best_clr) begin
			best_found_q <= 1'b0;
		end else if (cmp_vld_s1 && cmp_win) begin
			best_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_vld_s1 && cmp_win) begin
			best_prio_q  <= rd_prio;
			best_stamp_q <= rd_stamp;
			best_id_q    <= cmp_id_s1;
		end
	end

	assign best_id_wide = {{ID_W{1'b0}}, best_id_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_id_q    <= best_found_q ? best_id_wide[ID_W-1:0] : '0;
			out_empty_q <= !best_found_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(8-ID_W){1'b0}}, out_id_q};
	assign m_tuser  = out_empty_q;

	assign sts.op       = item_op_q;
	assign sts.in_range = item_in_range_q;
	assign sts.cnt_last = (cnt_q == AW'(TABLE_ENTRIES - 1));
	assign sts.rd_valid = rd_v;
	assign sts.out_free = !out_valid_q || m_tready;

endmodule

// File: src/ipt_ctrl.sv
// ----------------------------------------------------------------------------
// ipt_ctrl
// Controller: clearing sweep after reset, item dispatch, read-modify-write
// for increase, and the query scan over all entries.
// ----------------------------------------------------------------------------
module ipt_ctrl import ipt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  ipt_sts_t sts,
	output ipt_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.cnt_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (sts.op == OP_QUERY) begin
					state_d = ST_SCAN;
				end else if (sts.in_range && sts.op == OP_INCREASE) begin
					state_d = ST_MODIFY;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_MODIFY: state_d = ST_IDLE;
			ST_SCAN: begin
				if (sts.cnt_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_REPORT;
			ST_REPORT: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_we  = 1'b1;
				cmd.cnt_inc = !sts.cnt_last;
				cmd.cnt_clr = sts.cnt_last;
			end
			ST_IDLE: begin
				s_tready  = 1'b1;
				cmd.latch = s_tvalid;
			end
			ST_EXEC: begin
				if (sts.op == OP_QUERY) begin
					cmd.cnt_clr  = 1'b1;
					cmd.best_clr = 1'b1;
				end else if (sts.in_range) begin
					cmd.rd_item = (sts.op == OP_INCREASE);
					cmd.wr_item = (sts.op != OP_INCREASE);
				end
			end
			ST_MODIFY: begin
				cmd.wr_incr = sts.rd_valid;
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				cmd.cnt_inc = !sts.cnt_last;
				cmd.cnt_clr = sts.cnt_last;
			end
			ST_DRAIN: begin
			end
			ST_REPORT: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: src/indexed_priority_table.sv
// ----------------------------------------------------------------------------
// indexed_priority_table
// Table of up to TABLE_ENTRIES entries addressed by id, each with a priority
// and an arrival stamp. One beat carries one operation: insert (replaces a
// present id, fresh stamp), increase (saturating), remove, or query, which
// returns the highest-priority entry, earlier stamp and then lower id
// winning ties, or an empty flag. Only a query returns a beat. Insert and
// remove are a single write; increase is a memory read, then a write back;
// a query walks the entry memory through its single read port, one entry
// per cycle. After reset a clearing pass over all TABLE_ENTRIES entries
// runs before the first beat is taken.
// ----------------------------------------------------------------------------
module indexed_priority_table import ipt_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // entry_id[5:0], amount[15:6]
	input  logic [1:0]  s_tuser,   // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // top_id[5:0], zero pad[7:6]
	output logic [0:0]  m_tuser    // is_empty[0]
);

	ipt_cmd_t cmd;
	ipt_sts_t sts;

	ipt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ipt_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

`ifndef SYNTHESIS
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("beat accepted while previous item still in work");

	a_empty_id: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == 8'd0)
		else $error("empty result carries nonzero id");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !m_tvalid || m_tready)
		else $error("result register overwritten before taken");
`endif

endmodule
